// ----- sv/delimited_field_locator_assert.svh -----
// assertion macros for the delimited field locator
// expects signals named clock and reset in the including module
`ifndef DELIMITED_FIELD_LOCATOR_ASSERT_SVH
`define DELIMITED_FIELD_LOCATOR_ASSERT_SVH

// property checked on every clock edge outside reset
`define DFL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define DFL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/dfl_pkg.sv -----
// constants, types and helper functions for the delimited field locator
// no dependencies
package dfl_pkg;

   localparam int MAX_MARKER = 8;
   localparam int MAX_LENGTH = 65536;
   localparam int POS_W      = 17;    // holds MAX_LENGTH + 1
   localparam int IDX_W      = 16;
   localparam int LEN_W      = 4;
   localparam int MARKER_W   = 64;
   localparam int CSR_AW     = 5;

   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LENGTH);

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef enum logic [1:0] {
      CSR_START_MARKER = 2'd0,
      CSR_START_LEN    = 2'd1,
      CSR_END_MARKER   = 2'd2,
      CSR_END_LEN      = 2'd3
   } csr_index_type;

   function automatic logic is_text(input logic [7:0] c);
      return c != CHAR_SPACE && c != CHAR_LF && c != CHAR_CR &&
             c != CHAR_TAB && c != CHAR_NUL;
   endfunction

   // lengths above the marker capacity act as the full capacity
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
      return (len > LEN_W'(MAX_MARKER)) ? LEN_W'(MAX_MARKER) : len;
   endfunction

   function automatic logic [7:0] marker_byte(input logic [MARKER_W-1:0] marker,
                                              input logic [2:0]          k);
      return marker[8*k +: 8];
   endfunction

endpackage

// ----- sv/delimited_field_locator.sv -----
// delimited field locator: finds the trimmed field between start and end markers
// depends on dfl_pkg and delimited_field_locator_assert.svh
//
//  channel | dir    | contents
//  req     | in     | tdata[7:0] char_in, tlast is_last
//  rsp     | out    | one beat per stream, on the byte marked last
//  csr     | in/out | apb, 64-bit data, registers at byte address 8*i
//
// one byte per cycle sustained while no result waits on rsp; the marker compares
// and the back-scan over partial end-marker bytes run on the byte held in the
// input register, and the result beat is registered from them.
// reset is synchronous and clears the valid flags, the stream state and the csr registers.
// a result waiting on rsp stalls the input register; req_tready falls only then.
`include "delimited_field_locator_assert.svh"

module delimited_field_locator
   import dfl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // char_in
   input  logic                req_tlast,   // is_last
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,   // found, first_index[16], last_index[16],
                                            // overflow, zero pad[6]
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [MARKER_W-1:0] csr_pwdata,
   output logic [MARKER_W-1:0] csr_prdata,
   output logic                csr_pready
);

   // configuration
   logic [MARKER_W-1:0] start_marker_ff, end_marker_ff;
   logic [LEN_W-1:0]    start_len_ff, end_len_ff;
   csr_index_type       csr_index;

   // input register
   logic                in_valid_ff, in_last_ff;
   logic [7:0]          in_char_ff;

   // stream state
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [LEN_W-1:0]    sp_ff, sp_in, ep_ff, ep_in;
   logic                ss_ff, ss_in, es_ff, es_in;
   logic                fv_ff, fv_in, lv_ff, lv_in, stop_ff, stop_in;
   logic [IDX_W-1:0]    fp_ff, fp_in, lp_ff, lp_in;

   // result register
   logic                out_valid_ff;
   logic                found_ff, overflow_ff;
   logic [IDX_W-1:0]    first_ff, last_ff;

   logic                advance;
   logic                found_in, overflow_in;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[4:3]);

   always_comb begin
      case (csr_index)
         CSR_START_MARKER: csr_prdata = start_marker_ff;
         CSR_START_LEN:    csr_prdata = MARKER_W'(start_len_ff);
         CSR_END_MARKER:   csr_prdata = end_marker_ff;
         CSR_END_LEN:      csr_prdata = MARKER_W'(end_len_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= '0;
         start_len_ff    <= '0;
         end_marker_ff   <= '0;
         end_len_ff      <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_pwdata;
            CSR_START_LEN:    start_len_ff    <= csr_pwdata[LEN_W-1:0];
            CSR_END_MARKER:   end_marker_ff   <= csr_pwdata;
            CSR_END_LEN:      end_len_ff      <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_comb begin
      logic [LEN_W-1:0] sl, el, k, sp, ep;
      logic             ss, es, endm;
      logic [7:0]       c;

      c  = in_char_ff;
      sl = eff_len(start_len_ff);
      el = eff_len(end_len_ff);
      // first byte of a stream reloads the marker tracking from the lengths
      if (pos_ff == '0) begin
         ss = (sl == '0);
         es = (el == '0);
         sp = '0;
         ep = '0;
      end else begin
         ss = ss_ff;
         es = es_ff;
         sp = sp_ff;
         ep = ep_ff;
      end

      ss_in   = ss;
      es_in   = es;
      sp_in   = sp;
      ep_in   = ep;
      fv_in   = fv_ff;
      fp_in   = fp_ff;
      lv_in   = lv_ff;
      lp_in   = lp_ff;
      stop_in = stop_ff;
      endm    = 1'b0;
      k       = '0;

      if (pos_ff < POS_LIMIT && !stop_ff) begin
         if (!ss) begin
            if (sp >= sl || c == marker_byte(start_marker_ff, sp[2:0])) begin
               sp_in = sp + 1'b1;
               ss_in = (sp + 1'b1) >= sl;
            end else begin
               sp_in = '0;
            end
         end else begin
            if (!fv_ff && is_text(c)) begin
               fv_in = 1'b1;
               fp_in = pos_ff[IDX_W-1:0];
            end
            endm = !es && (ep >= el || c == marker_byte(end_marker_ff, ep[2:0]));
            if (endm) begin
               ep_in = ep + 1'b1;
               if ((ep + 1'b1) >= el) begin
                  es_in   = 1'b1;
                  stop_in = 1'b1;
               end
            end else begin
               // partially matched end-marker bytes turn out to be field text
               k = es ? '0 : ep;
               for (int j = 0; j < MAX_MARKER; j++) begin
                  if (LEN_W'(j) < k && is_text(marker_byte(end_marker_ff, 3'(j)))) begin
                     lv_in = 1'b1;
                     lp_in = pos_ff[IDX_W-1:0] - IDX_W'(k) + IDX_W'(j);
                  end
               end
               if (is_text(c)) begin
                  lv_in = 1'b1;
                  lp_in = pos_ff[IDX_W-1:0];
               end
               ep_in = '0;
            end
         end
      end

      pos_in      = (pos_ff <= POS_LIMIT) ? pos_ff + 1'b1 : pos_ff;
      found_in    = es_in && fv_in && lv_in;
      overflow_in = pos_in > POS_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sp_ff   <= '0;
         ep_ff   <= '0;
         ss_ff   <= 1'b0;
         es_ff   <= 1'b0;
         fv_ff   <= 1'b0;
         fp_ff   <= '0;
         lv_ff   <= 1'b0;
         lp_ff   <= '0;
         stop_ff <= 1'b0;
      end else if (advance) begin
         if (in_last_ff) begin
            pos_ff  <= '0;
            sp_ff   <= '0;
            ep_ff   <= '0;
            ss_ff   <= 1'b0;
            es_ff   <= 1'b0;
            fv_ff   <= 1'b0;
            fp_ff   <= '0;
            lv_ff   <= 1'b0;
            lp_ff   <= '0;
            stop_ff <= 1'b0;
         end else begin
            pos_ff  <= pos_in;
            sp_ff   <= sp_in;
            ep_ff   <= ep_in;
            ss_ff   <= ss_in;
            es_ff   <= es_in;
            fv_ff   <= fv_in;
            fp_ff   <= fp_in;
            lv_ff   <= lv_in;
            lp_ff   <= lp_in;
            stop_ff <= stop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && in_last_ff) begin
         found_ff    <= found_in;
         first_ff    <= found_in ? fp_in : '0;
         last_ff     <= found_in ? lp_in : '0;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, overflow_ff, last_ff, first_ff, found_ff};

   `DFL_ASSERT(a_pos_bounded, pos_ff <= POS_LIMIT + 1'b1, "byte position past saturation")
   `DFL_ASSERT(a_stop_needs_end, !stop_ff || es_ff, "search stopped without end match")
   `DFL_ASSERT_NEXT(a_last_clears, advance && in_last_ff, pos_ff == '0 && rsp_tvalid,
      "last beat did not clear stream and raise result")
   `DFL_ASSERT(a_result_source, !$rose(out_valid_ff) || $past(advance && in_last_ff),
      "result raised without a last beat")

endmodule
